// ----- src/bounded_deque_unit_defines.svh -----
// Assertion macros used by the bounded deque unit datapath.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef BOUNDED_DEQUE_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BDQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BDQ_ASSERT_CLK(lbl, prop, msg) `BDQ_ASSERT(lbl, aclk, aresetn, prop, msg)
`else
`define BDQ_ASSERT(lbl, clk, rstn, prop, msg)
`define BDQ_ASSERT_CLK(lbl, prop, msg)
`endif
`endif

// ----- src/bdq_pkg.sv -----
// Types and constants for the bounded deque unit.
// Used by the controller, the datapath and the top level; no dependencies.
package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(DEPTH);
    localparam logic [IDX_W:0]   DEPTH_RING = (IDX_W + 1)'(DEPTH);

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_DUMP       = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        RS_OK    = 2'd0,
        RS_EMPTY = 2'd1,
        RS_FULL  = 2'd2
    } rstat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_DUMP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   load_item;
        logic   rd_en;
        logic   commit;
        logic   dump_clear;
        logic   dump_step;
        logic   emit;
        rstat_t emit_status;
        logic   emit_data;
        logic   emit_last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t cmd;
        logic empty;
        logic full;
        logic dump_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- src/bdq_ctrl.sv -----
// Controller state machine of the bounded deque unit.
// Depends on bdq_pkg; drives the datapath through dp_cmd_t.
module bdq_ctrl import bdq_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (stat.cmd)
                    CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                        if (stat.out_free) begin
                            state_next = ST_IDLE;
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK: begin
                        if (!stat.empty) begin
                            state_next = ST_POP;
                        end else if (stat.out_free) begin
                            state_next = ST_IDLE;
                        end
                    end
                    CMD_DUMP: begin
                        if (!stat.empty) begin
                            state_next = ST_DUMP;
                        end else if (stat.out_free) begin
                            state_next = ST_IDLE;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_POP: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP: begin
                if (stat.out_free && stat.dump_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl     = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                ctrl.load_item = s_tvalid;
            end
            ST_EXEC: begin
                case (stat.cmd)
                    CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                        if (stat.out_free) begin
                            ctrl.emit        = 1'b1;
                            ctrl.emit_status = stat.full ? RS_FULL : RS_OK;
                            ctrl.emit_last   = 1'b1;
                            ctrl.commit      = !stat.full;
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK, CMD_DUMP: begin
                        if (!stat.empty) begin
                            // Start the store read; POP or DUMP emits the value.
                            ctrl.rd_en      = 1'b1;
                            ctrl.dump_clear = (stat.cmd == CMD_DUMP);
                        end else if (stat.out_free) begin
                            ctrl.emit        = 1'b1;
                            ctrl.emit_status = RS_EMPTY;
                            ctrl.emit_last   = 1'b1;
                        end
                    end
                    default: begin
                        ctrl = '0;
                    end
                endcase
            end
            ST_POP: begin
                if (stat.out_free) begin
                    ctrl.emit        = 1'b1;
                    ctrl.emit_status = RS_OK;
                    ctrl.emit_data   = 1'b1;
                    ctrl.emit_last   = 1'b1;
                    ctrl.commit      = 1'b1;
                end
            end
            ST_DUMP: begin
                if (stat.out_free) begin
                    // Each transfer but the last also fetches the following entry.
                    ctrl.emit        = 1'b1;
                    ctrl.emit_status = RS_OK;
                    ctrl.emit_data   = 1'b1;
                    ctrl.emit_last   = stat.dump_last;
                    ctrl.dump_step   = !stat.dump_last;
                    ctrl.rd_en       = !stat.dump_last;
                end
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

endmodule

// ----- src/bdq_dp.sv -----
// Datapath of the bounded deque unit: ring store, pointers and output register.
// Depends on bdq_pkg and the assertion macros in bounded_deque_unit_defines.svh.
`include "bounded_deque_unit_defines.svh"
module bdq_dp import bdq_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [2:0]        s_tuser,
    input  logic [DATA_W-1:0] s_tdata,
    input  dp_cmd_t           ctrl,
    output dp_stat_t          stat,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [DATA_W-1:0] m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_RING) begin
            sum = sum - DEPTH_RING;
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [DATA_W-1:0] store_mem [DEPTH];

    cmd_t              cmd_reg;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  dump_idx_reg, dump_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    rstat_t            out_status_reg;
    logic              out_last_reg;

    logic [IDX_W-1:0] front_dec, front_inc, back_pos, tail_pos;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             is_push, is_pop, mem_we;

    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - IDX_W'(1);
    assign front_inc = ring_add(front_reg, IDX_W'(1));
    assign back_pos  = ring_add(front_reg, count_reg[IDX_W-1:0] - IDX_W'(1));
    // Only used when the queue is not full, so the count fits the index.
    assign tail_pos  = ring_add(front_reg, count_reg[IDX_W-1:0]);

    assign is_push = (cmd_reg == CMD_PUSH_FRONT) || (cmd_reg == CMD_PUSH_BACK);
    assign is_pop  = (cmd_reg == CMD_POP_FRONT) || (cmd_reg == CMD_POP_BACK);
    assign mem_we  = ctrl.commit && is_push;
    assign wr_addr = (cmd_reg == CMD_PUSH_FRONT) ? front_dec : tail_pos;

    always_comb begin
        dump_idx_next = dump_idx_reg;
        if (ctrl.dump_clear) begin
            dump_idx_next = '0;
        end else if (ctrl.dump_step) begin
            dump_idx_next = dump_idx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        case (cmd_reg)
            CMD_POP_FRONT: rd_addr = front_reg;
            CMD_POP_BACK:  rd_addr = back_pos;
            default:       rd_addr = ring_add(front_reg, dump_idx_next);
        endcase
    end

    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        if (ctrl.commit) begin
            case (cmd_reg)
                CMD_PUSH_FRONT: begin
                    front_next = front_dec;
                    count_next = count_reg + CNT_W'(1);
                end
                CMD_PUSH_BACK: begin
                    count_next = count_reg + CNT_W'(1);
                end
                CMD_POP_FRONT: begin
                    front_next = front_inc;
                    count_next = count_reg - CNT_W'(1);
                end
                CMD_POP_BACK: begin
                    count_next = count_reg - CNT_W'(1);
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctrl.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_item) begin
            cmd_reg   <= cmd_t'(s_tuser);
            value_reg <= s_tdata;
        end
        dump_idx_reg <= dump_idx_next;
        if (ctrl.emit) begin
            out_data_reg   <= ctrl.emit_data ? rd_data_reg : '0;
            out_status_reg <= ctrl.emit_status;
            out_last_reg   <= ctrl.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[wr_addr] <= value_reg;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign stat.cmd       = cmd_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == DEPTH_CNT);
    assign stat.dump_last = ((CNT_W'(dump_idx_reg) + CNT_W'(1)) == count_reg);
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    `BDQ_ASSERT_CLK(a_count_bound, count_reg <= DEPTH_CNT, "entry count exceeds capacity")
    `BDQ_ASSERT_CLK(a_emit_room, ctrl.emit |-> stat.out_free, "result overwrites pending one")
    `BDQ_ASSERT_CLK(a_no_push_full, mem_we |-> !stat.full, "push committed into full queue")
    `BDQ_ASSERT_CLK(a_pop_count, (ctrl.commit && is_pop) |=> (count_reg == $past(count_reg) - CNT_W'(1)), "pop did not drop count")

endmodule

// ----- src/bounded_deque_unit.sv -----
// Top level of the bounded deque unit.
// Depends on bdq_pkg, bdq_ctrl and bdq_dp.
// A double-ended queue of up to 16 signed 32-bit values in a ring store. The
// command arrives in s_tuser and the value in s_tdata; each accepted item
// produces one result transfer, except a dump of a non-empty queue, which sends
// one transfer per stored entry from front to back with m_tlast on the final
// one, and an undefined command, which sends nothing. Items are handled one at
// a time: a push, or a pop or dump meeting an empty queue, has its result
// loaded into the output register from the execute state; a pop first reads
// the store, which has a registered read port, and a dump reads its entries
// in turn. The next item is accepted in the cycle after the last result of the
// previous one is loaded into the output register, so a result waiting on
// m_tready does not hold off the next input transfer.
module bounded_deque_unit import bdq_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [2:0]        s_tuser,   // [2:0] cmd
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [31:0] result_value
    output logic [1:0]        m_tuser,   // [1:0] status
    output logic              m_tlast
);

    dp_cmd_t  ctrl;
    dp_stat_t stat;

    bdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    bdq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .ctrl     (ctrl),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
